// ===== design/mpcb_pkg.sv =====
// Package: kinds, status codes, widths and defaults for the capture buffer.
`default_nettype none
package mpcb_pkg;
   localparam int GROUPS_DEF = 2;
   localparam int CPG_DEF = 16;
   localparam int FIFO_DEPTH_DEF = 16;
   localparam int MAX_CH = 32;
   localparam int CHW = 5;
   localparam int PERW = 16;
   localparam int DATAW = 32;

   typedef enum logic [2:0] {
      KIND_TICK = 3'd0, KIND_ALLOC = 3'd1, KIND_START = 3'd2,
      KIND_READ = 3'd3, KIND_QUERY = 3'd4, KIND_RECONF = 3'd5,
      KIND_NONE6 = 3'd6, KIND_NONE7 = 3'd7
   } kind_type;

   localparam logic [1:0] ST_OK = 2'd0;
   localparam logic [1:0] ST_EMPTY = 2'd1;
   localparam logic [1:0] ST_NOCH = 2'd2;
   localparam logic [1:0] ST_FULL = 2'd3;

   localparam logic [1:0] CS_IDLE = 2'd0;
   localparam logic [1:0] CS_CACHING = 2'd1;
   localparam logic [1:0] CS_HOLDING = 2'd2;

   typedef struct packed {
      kind_type          kind;
      logic [CHW-1:0]    channel;
      logic [PERW-1:0]   period;
      logic [DATAW-1:0]  sample;
   } item_type;
endpackage
`default_nettype wire

// ===== design/multichannel_periodic_capture_buffer_core.sv =====
// Multichannel periodic capture buffer, top level.
// One result per item. Tick, allocate, start, query and reconfigure are handled directly in the
// channel engine; a read also waits on the registered read port of the sample memory.
// A two-entry queue decouples the request port from the engine, so requests are taken while
// a result waits to be transferred; the engine starts its next item once its result is gone.
`default_nettype none
module multichannel_periodic_capture_buffer_core
   import mpcb_pkg::*;
#(
   parameter int GROUPS = GROUPS_DEF,
   parameter int CHANNELS_PER_GROUP = CPG_DEF,
   parameter int FIFO_DEPTH = FIFO_DEPTH_DEF
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire logic [2:0]       req_kind,
   input  wire logic [CHW-1:0]   req_channel,
   input  wire logic [PERW-1:0]  req_period,
   input  wire logic [DATAW-1:0] req_sample,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output logic [1:0]            rsp_status,
   output logic [CHW-1:0]        rsp_granted_channel,
   output logic [DATAW-1:0]      rsp_read_data,
   output logic [1:0]            rsp_cache_state,
   output logic                  rsp_capture_end
);
   item_type req_item, q_item;
   logic     q_valid, q_ready;

   assign req_item = '{kind: kind_type'(req_kind), channel: req_channel,
                       period: req_period, sample: req_sample};

   mpcb_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_item   (req_item),
      .out_valid (q_valid),
      .out_ready (q_ready),
      .out_item  (q_item)
   );

   mpcb_exec #(
      .GROUPS             (GROUPS),
      .CHANNELS_PER_GROUP (CHANNELS_PER_GROUP),
      .FIFO_DEPTH         (FIFO_DEPTH)
   ) u_exec (
      .clock               (clock),
      .reset               (reset),
      .in_valid            (q_valid),
      .in_ready            (q_ready),
      .in_item             (q_item),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_status          (rsp_status),
      .rsp_granted_channel (rsp_granted_channel),
      .rsp_read_data       (rsp_read_data),
      .rsp_cache_state     (rsp_cache_state),
      .rsp_capture_end     (rsp_capture_end)
   );
endmodule
`default_nettype wire

// ===== design/mpcb_ram.sv =====
// Generic single-port write, single-port registered read RAM.
`default_nettype none
module mpcb_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 512
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end
endmodule
`default_nettype wire

// ===== design/mpcb_queue.sv =====
// Two-entry queue between the front and the back part.
`default_nettype none
module mpcb_queue
   import mpcb_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     in_valid,
   output logic          in_ready,
   input  wire item_type in_item,
   output logic          out_valid,
   input  wire logic     out_ready,
   output item_type      out_item
);
   item_type  slot_ff [2];
   logic      wptr_ff, wptr_in, rptr_ff, rptr_in;
   logic [1:0] cnt_ff, cnt_in;
   logic      push, pop;

   assign in_ready  = (cnt_ff != 2'd2);
   assign out_valid = (cnt_ff != 2'd0);
   assign out_item  = slot_ff[rptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_comb begin
      wptr_in = push ? ~wptr_ff : wptr_ff;
      rptr_in = pop ? ~rptr_ff : rptr_ff;
      cnt_in  = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= 1'b0;
         rptr_ff <= 1'b0;
         cnt_ff  <= 2'd0;
      end else begin
         wptr_ff <= wptr_in;
         rptr_ff <= rptr_in;
         cnt_ff  <= cnt_in;
      end
      if (push) begin
         slot_ff[wptr_ff] <= in_item;
      end
   end

   assert property (@(posedge clock) disable iff (reset) cnt_ff != 2'd3)
      else $error("queue count out of range");
   assert property (@(posedge clock) disable iff (reset)
      (cnt_ff == 2'd2 && !pop) |=> cnt_ff == 2'd2)
      else $error("full queue lost an entry");
   assert property (@(posedge clock) disable iff (reset)
      (cnt_ff == 2'd0) |-> !out_valid)
      else $error("empty queue shows valid");
endmodule
`default_nettype wire

// ===== design/mpcb_exec.sv =====
// Back part: channel tables, per-channel fifo bookkeeping and the sample memory.
`default_nettype none
module mpcb_exec
   import mpcb_pkg::*;
#(
   parameter int GROUPS = GROUPS_DEF,
   parameter int CHANNELS_PER_GROUP = CPG_DEF,
   parameter int FIFO_DEPTH = FIFO_DEPTH_DEF
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             in_valid,
   output logic                  in_ready,
   input  wire item_type         in_item,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output logic [1:0]            rsp_status,
   output logic [CHW-1:0]        rsp_granted_channel,
   output logic [DATAW-1:0]      rsp_read_data,
   output logic [1:0]            rsp_cache_state,
   output logic                  rsp_capture_end
);
   localparam int NCH_RAW = GROUPS * CHANNELS_PER_GROUP;
   localparam int NCH = (NCH_RAW < MAX_CH) ? NCH_RAW : MAX_CH;
   localparam int PW = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
   localparam int FW = $clog2(FIFO_DEPTH + 1);
   localparam int AW = CHW + PW;
   localparam logic [PW-1:0] LAST = PW'(FIFO_DEPTH - 1);
   localparam logic [FW-1:0] FULL = FW'(FIFO_DEPTH);

   logic [MAX_CH-1:0] alloc_ff, alloc_in, armed_ff, armed_in;
   logic [PERW-1:0]   cnt_ff [MAX_CH];
   logic [PERW-1:0]   per_ff [MAX_CH];
   logic [PW-1:0]     head_ff [MAX_CH];
   logic [PW-1:0]     tail_ff [MAX_CH];
   logic [FW-1:0]     fill_ff [MAX_CH];

   logic              busy_ff, busy_in;
   logic              rvalid_ff, rvalid_in;
   logic              rdwait_ff, rdwait_in;
   logic [1:0]        status_ff, status_in, cstate_ff, cstate_in;
   logic [CHW-1:0]    grant_ff, grant_in;
   logic              end_ff, end_in;
   logic [DATAW-1:0]  data_ff;

   logic              take, exists, inrange, found, wr_en, wr_ch_en, do_clear;
   logic [CHW-1:0]    c, free_ch, wr_ch;
   logic [PERW-1:0]   cnt_inc, wr_cnt, wr_per;
   logic [PW-1:0]     wr_head, wr_tail, head_nx, tail_nx;
   logic [FW-1:0]     wr_fill;
   logic [AW-1:0]     wr_addr, rd_addr;
   logic [DATAW-1:0]  ram_q;

   assign c        = in_item.channel;
   assign in_ready = !rvalid_ff && !rdwait_ff;
   assign take     = in_valid && in_ready;
   assign inrange  = ({1'b0, c} < (CHW+1)'(NCH));
   assign exists   = inrange && alloc_ff[c];
   assign cnt_inc  = cnt_ff[c] + 16'd1;
   assign head_nx  = (head_ff[c] == LAST) ? '0 : head_ff[c] + 1'b1;
   assign tail_nx  = (tail_ff[c] == LAST) ? '0 : tail_ff[c] + 1'b1;
   assign wr_addr  = {c, tail_ff[c]};
   assign rd_addr  = {c, head_ff[c]};

   always_comb begin
      found   = 1'b0;
      free_ch = '0;
      for (int i = NCH - 1; i >= 0; i--) begin
         if (!alloc_ff[i]) begin
            found   = 1'b1;
            free_ch = CHW'(i);
         end
      end
   end

   always_comb begin
      alloc_in  = alloc_ff;
      armed_in  = armed_ff;
      rvalid_in = rvalid_ff;
      rdwait_in = 1'b0;
      busy_in   = busy_ff;
      status_in = status_ff;
      cstate_in = cstate_ff;
      grant_in  = grant_ff;
      end_in    = end_ff;
      wr_en     = 1'b0;
      wr_ch_en  = 1'b0;
      do_clear  = 1'b0;
      wr_ch     = c;
      wr_cnt    = cnt_ff[c];
      wr_per    = per_ff[c];
      wr_head   = head_ff[c];
      wr_tail   = tail_ff[c];
      wr_fill   = fill_ff[c];
      if (rvalid_ff && rsp_ready) begin
         rvalid_in = 1'b0;
      end
      if (rdwait_ff) begin
         rvalid_in = 1'b1;
      end
      if (take) begin
         status_in = ST_OK;
         cstate_in = CS_IDLE;
         grant_in  = '0;
         end_in    = 1'b0;
         rvalid_in = 1'b1;
         unique case (in_item.kind)
            KIND_TICK: begin
               if (!exists) begin
                  status_in = ST_NOCH;
               end else if (armed_ff[c]) begin
                  wr_ch_en = 1'b1;
                  wr_cnt   = cnt_inc;
                  if (cnt_inc >= per_ff[c]) begin
                     wr_cnt = '0;
                     if (fill_ff[c] < FULL) begin
                        wr_en   = 1'b1;
                        wr_tail = tail_nx;
                        wr_fill = fill_ff[c] + 1'b1;
                     end
                     if (wr_fill >= FULL) begin
                        armed_in[c] = 1'b0;
                        end_in      = 1'b1;
                     end
                  end
               end
            end
            KIND_ALLOC: begin
               if (!found) begin
                  status_in = ST_FULL;
               end else begin
                  wr_ch           = free_ch;
                  alloc_in[free_ch] = 1'b1;
                  armed_in[free_ch] = 1'b0;
                  wr_per          = in_item.period;
                  do_clear        = 1'b1;
                  grant_in        = free_ch;
               end
            end
            KIND_START: begin
               if (!exists) status_in = ST_NOCH;
               else armed_in[c] = 1'b1;
            end
            KIND_READ: begin
               if (!exists) begin
                  status_in = ST_NOCH;
               end else if (fill_ff[c] == '0) begin
                  status_in = ST_EMPTY;
               end else begin
                  rvalid_in = 1'b0;
                  rdwait_in = 1'b1;
                  wr_ch_en  = 1'b1;
                  wr_head   = head_nx;
                  wr_fill   = fill_ff[c] - 1'b1;
               end
            end
            KIND_QUERY: begin
               if (!inrange) status_in = ST_NOCH;
               else if (armed_ff[c]) cstate_in = CS_CACHING;
               else if (fill_ff[c] != '0) cstate_in = CS_HOLDING;
            end
            KIND_RECONF: begin
               if (!exists) begin
                  status_in = ST_NOCH;
               end else begin
                  armed_in[c] = 1'b0;
                  wr_per      = in_item.period;
                  do_clear    = 1'b1;
               end
            end
            KIND_NONE6, KIND_NONE7: begin
            end
         endcase
      end
      busy_in = rvalid_in || rdwait_in;
      if (do_clear) begin
         wr_ch_en = 1'b1;
         wr_cnt   = '0;
         wr_head  = '0;
         wr_tail  = '0;
         wr_fill  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         alloc_ff  <= '0;
         armed_ff  <= '0;
         rvalid_ff <= 1'b0;
         rdwait_ff <= 1'b0;
         busy_ff   <= 1'b0;
         for (int i = 0; i < MAX_CH; i++) begin
            cnt_ff[i]  <= '0;
            per_ff[i]  <= '0;
            head_ff[i] <= '0;
            tail_ff[i] <= '0;
            fill_ff[i] <= '0;
         end
      end else begin
         alloc_ff  <= alloc_in;
         armed_ff  <= armed_in;
         rvalid_ff <= rvalid_in;
         rdwait_ff <= rdwait_in;
         busy_ff   <= busy_in;
         if (wr_ch_en) begin
            cnt_ff[wr_ch]  <= wr_cnt;
            per_ff[wr_ch]  <= wr_per;
            head_ff[wr_ch] <= wr_head;
            tail_ff[wr_ch] <= wr_tail;
            fill_ff[wr_ch] <= wr_fill;
         end
      end
      status_ff <= status_in;
      cstate_ff <= cstate_in;
      grant_ff  <= grant_in;
      end_ff    <= end_in;
      if (take) data_ff <= '0;
      else if (rdwait_ff) data_ff <= ram_q;
   end

   mpcb_ram #(.WIDTH(DATAW), .DEPTH(MAX_CH * (1 << PW))) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (in_item.sample),
      .rd_addr (rd_addr),
      .rd_data (ram_q)
   );

   assign rsp_valid           = rvalid_ff;
   assign rsp_status          = status_ff;
   assign rsp_granted_channel = grant_ff;
   assign rsp_read_data       = data_ff;
   assign rsp_cache_state     = cstate_ff;
   assign rsp_capture_end     = end_ff;

   assert property (@(posedge clock) disable iff (reset) !(rvalid_ff && rdwait_ff))
      else $error("result shown while read pending");
   assert property (@(posedge clock) disable iff (reset) rdwait_ff |=> rvalid_ff)
      else $error("read result not produced");
   assert property (@(posedge clock) disable iff (reset) (armed_ff & ~alloc_ff) == '0)
      else $error("armed channel not allocated");
   assert property (@(posedge clock) disable iff (reset) busy_ff == (rvalid_ff || rdwait_ff))
      else $error("busy flag mismatch");
endmodule
`default_nettype wire

// ===== verif/mpcb_checker.sv =====
// Checker: predicts capture buffer responses from observed requests and compares them.
`timescale 1ns / 100ps
module mpcb_checker
   import mpcb_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   input  wire logic             req_ready,
   input  wire logic [2:0]       req_kind,
   input  wire logic [CHW-1:0]   req_channel,
   input  wire logic [PERW-1:0]  req_period,
   input  wire logic [DATAW-1:0] req_sample,
   input  wire logic             rsp_valid,
   input  wire logic             rsp_ready,
   input  wire logic [1:0]       rsp_status,
   input  wire logic [CHW-1:0]   rsp_granted_channel,
   input  wire logic [DATAW-1:0] rsp_read_data,
   input  wire logic [1:0]       rsp_cache_state,
   input  wire logic             rsp_capture_end,
   output int                    fail_count,
   output int                    pending_count,
   output int                    rsp_count
);
   localparam int NCH = GROUPS_DEF * CPG_DEF < 32 ? GROUPS_DEF * CPG_DEF : 32;
   localparam int DEPTH = FIFO_DEPTH_DEF;

   typedef struct packed {
      logic [1:0]       status;
      logic [CHW-1:0]   granted;
      logic [DATAW-1:0] data;
      logic [1:0]       cstate;
      logic             cap_end;
   } answer_type;

   answer_type answer_queue[$];
   logic [31:0] alloc_bits, armed_bits;
   logic [15:0] counter[32];
   logic [15:0] period_of[32];
   logic [31:0] samples[32][DEPTH];
   int head[32], tail[32], fill[32];

   function automatic answer_type capture_step(logic [2:0] kind, int c,
                                               logic [15:0] per, logic [31:0] smp);
      answer_type a;
      bit exists;
      int i;
      a = '0;
      exists = c < NCH && alloc_bits[c];
      case (kind_type'(kind))
         KIND_TICK: begin
            if (!exists) a.status = ST_NOCH;
            else if (armed_bits[c]) begin
               counter[c] = counter[c] + 16'd1;
               if (counter[c] >= period_of[c]) begin
                  counter[c] = '0;
                  if (fill[c] < DEPTH) begin
                     samples[c][tail[c]] = smp;
                     tail[c] = (tail[c] + 1) % DEPTH;
                     fill[c]++;
                  end
                  if (fill[c] >= DEPTH) begin
                     armed_bits[c] = 1'b0;
                     a.cap_end = 1'b1;
                  end
               end
            end
         end
         KIND_ALLOC: begin
            for (i = 0; i < NCH; i++) if (!alloc_bits[i]) break;
            if (i == NCH) a.status = ST_FULL;
            else begin
               alloc_bits[i] = 1'b1;
               armed_bits[i] = 1'b0;
               period_of[i] = per;
               counter[i] = '0;
               head[i] = 0; tail[i] = 0; fill[i] = 0;
               a.granted = i[CHW-1:0];
            end
         end
         KIND_START: begin
            if (!exists) a.status = ST_NOCH;
            else armed_bits[c] = 1'b1;
         end
         KIND_READ: begin
            if (!exists) a.status = ST_NOCH;
            else if (fill[c] == 0) a.status = ST_EMPTY;
            else begin
               a.data = samples[c][head[c]];
               head[c] = (head[c] + 1) % DEPTH;
               fill[c]--;
            end
         end
         KIND_QUERY: begin
            if (c >= NCH) a.status = ST_NOCH;
            else if (armed_bits[c]) a.cstate = CS_CACHING;
            else if (fill[c] != 0) a.cstate = CS_HOLDING;
         end
         KIND_RECONF: begin
            if (!exists) a.status = ST_NOCH;
            else begin
               armed_bits[c] = 1'b0;
               period_of[c] = per;
               counter[c] = '0;
               head[c] = 0; tail[c] = 0; fill[c] = 0;
            end
         end
         default: ;
      endcase
      return a;
   endfunction

   always @(posedge clock) begin
      answer_type want, got;
      if (reset) begin
         alloc_bits = '0;
         armed_bits = '0;
         for (int k = 0; k < 32; k++) begin
            counter[k] = '0; period_of[k] = '0;
            head[k] = 0; tail[k] = 0; fill[k] = 0;
         end
         answer_queue.delete();
         fail_count <= 0;
         rsp_count <= 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            got = '{rsp_status, rsp_granted_channel, rsp_read_data, rsp_cache_state,
                    rsp_capture_end};
            rsp_count <= rsp_count + 1;
            if (answer_queue.size() == 0) begin
               $display("%0t: unexpected response %h", $time, got);
               fail_count <= fail_count + 1;
            end else begin
               want = answer_queue.pop_front();
               if (got !== want) begin
                  $display("%0t: mismatch expected status %0d grant %0d data %h state %0d end %0b",
                           $time, want.status, want.granted, want.data, want.cstate,
                           want.cap_end);
                  $display("%0t:          actual status %0d grant %0d data %h state %0d end %0b",
                           $time, got.status, got.granted, got.data, got.cstate, got.cap_end);
                  fail_count <= fail_count + 1;
               end
            end
         end
         if (req_valid && req_ready)
            answer_queue.push_back(capture_step(req_kind, int'(req_channel), req_period,
                                                req_sample));
      end
      pending_count <= answer_queue.size();
   end
endmodule

// ===== verif/tb_top.sv =====
// Testbench top: drives capture buffer requests, applies back-pressure, reports verdict.
`timescale 1ns / 100ps
module tb_top;
   import mpcb_pkg::*;

   logic clock, reset;
   logic req_valid, req_ready;
   logic [2:0] req_kind;
   logic [CHW-1:0] req_channel;
   logic [PERW-1:0] req_period;
   logic [DATAW-1:0] req_sample;
   logic rsp_valid, rsp_ready;
   logic [1:0] rsp_status, rsp_cache_state;
   logic [CHW-1:0] rsp_granted_channel;
   logic [DATAW-1:0] rsp_read_data;
   logic rsp_capture_end;
   int fail_count, pending_count, rsp_count;
   int send_idle_pct, recv_idle_pct;
   bit hold_off;
   int item_count;

   multichannel_periodic_capture_buffer_core DUT (.*);

   mpcb_checker checker_inst (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #50ms;
      $display("tb_top failed");
      $finish;
   end

   // receiver
   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_ready <= !hold_off && ($urandom_range(99) >= recv_idle_pct);
      end
   end

   task automatic send(logic [2:0] kind, logic [4:0] ch, logic [15:0] per, logic [31:0] smp);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_kind <= kind;
      req_channel <= ch;
      req_period <= per;
      req_sample <= smp;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
      item_count++;
   endtask

   task automatic random_item();
      int r;
      logic [4:0] ch;
      r = $urandom_range(99);
      ch = ($urandom_range(9) == 0) ? 5'($urandom) : 5'($urandom_range(5));
      if (r < 50) send(KIND_TICK, ch, 16'($urandom), $urandom);
      else if (r < 56) send(KIND_ALLOC, 5'($urandom), 16'($urandom_range(3)), $urandom);
      else if (r < 64) send(KIND_START, ch, 16'($urandom), $urandom);
      else if (r < 82) send(KIND_READ, ch, 16'($urandom), $urandom);
      else if (r < 90) send(KIND_QUERY, ch, 16'($urandom), $urandom);
      else if (r < 97) send(KIND_RECONF, ch,
                            ($urandom_range(19) == 0) ? 16'($urandom) : 16'($urandom_range(3)),
                            $urandom);
      else send(3'($urandom_range(7, 6)), ch, 16'($urandom), $urandom);
   endtask

   initial begin
      req_valid = 1'b0;
      req_kind = KIND_TICK;
      req_channel = '0;
      req_period = '0;
      req_sample = '0;
      hold_off = 1'b0;
      send_idle_pct = 0;
      recv_idle_pct = 0;
      item_count = 0;
      reset = 1'b1;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: unallocated channels, period zero, fill to end
      send(KIND_QUERY, 5'd31, 16'd0, 32'd0);
      send(KIND_QUERY, 5'd3, 16'd0, 32'd0);
      send(KIND_TICK, 5'd0, 16'd0, 32'd0);
      send(KIND_READ, 5'd0, 16'd0, 32'd0);
      send(KIND_ALLOC, 5'd0, 16'd0, 32'd0);
      send(KIND_ALLOC, 5'd0, 16'hffff, 32'd0);
      send(KIND_READ, 5'd0, 16'd0, 32'd0);
      send(KIND_START, 5'd0, 16'd0, 32'd0);
      for (int k = 0; k < 17; k++) send(KIND_TICK, 5'd0, 16'd0, k[0] ? 32'hffffffff : 32'd0);
      send(KIND_QUERY, 5'd0, 16'd0, 32'd0);
      send(KIND_START, 5'd0, 16'd0, 32'd0);
      send(KIND_TICK, 5'd0, 16'd0, 32'h5a5a5a5a);
      send(KIND_READ, 5'd0, 16'd0, 32'd0);
      send(KIND_TICK, 5'd1, 16'd0, 32'd1);
      send(KIND_RECONF, 5'd1, 16'd1, 32'd0);
      send(KIND_START, 5'd1, 16'd0, 32'd0);
      send(KIND_QUERY, 5'd1, 16'd0, 32'd0);
      send(KIND_NONE6, 5'd1, 16'd0, 32'd0);
      send(KIND_NONE7, 5'd31, 16'hffff, 32'hffffffff);
      for (int k = 0; k < 32; k++) send(KIND_ALLOC, 5'd0, 16'($urandom_range(2)), 32'd0);
      send(KIND_START, 5'd31, 16'd0, 32'd0);
      send(KIND_RECONF, 5'd31, 16'd0, 32'd0);

      // long receiver hold-off while the sender keeps offering
      fork
         begin
            hold_off = 1'b1;
            repeat (200) @(negedge clock);
            hold_off = 1'b0;
         end
         for (int k = 0; k < 20; k++) send(KIND_QUERY, 5'(k), 16'd0, 32'd0);
      join

      send_idle_pct = 17; recv_idle_pct = 52;
      for (int k = 0; k < 420; k++) random_item();
      send_idle_pct = 52; recv_idle_pct = 17;
      for (int k = 0; k < 420; k++) random_item();
      send_idle_pct = 0; recv_idle_pct = 0;
      for (int k = 0; k < 410; k++) random_item();
      req_valid <= 1'b0;

      while (pending_count != 0) @(negedge clock);
      repeat (20) @(negedge clock);
      $display("Sent %0d requests over all kinds and channel ranges; checked %0d responses.",
               item_count, rsp_count);
      if (fail_count == 0 && pending_count == 0) $display("tb_top passed");
      else $display("tb_top failed");
      $finish;
   end
endmodule

// ===== filelist.f =====
design/mpcb_pkg.sv
design/mpcb_ram.sv
design/mpcb_queue.sv
design/mpcb_exec.sv
design/multichannel_periodic_capture_buffer_core.sv
verif/mpcb_checker.sv
verif/tb_top.sv
